@@ rtl/irqlm_pkg.sv @@
package irqlm_pkg;

    localparam int LINE_W   = 6;
    localparam int VEC_W    = 8;
    localparam int DEST_W   = 8;
    localparam int COUNT_W  = 7;
    localparam int LIMIT_W  = 9;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [2:0] OP_CONFIGURE = 3'd0;
    localparam logic [2:0] OP_ENABLE    = 3'd1;
    localparam logic [2:0] OP_DISABLE   = 3'd2;
    localparam logic [2:0] OP_MASK      = 3'd3;
    localparam logic [2:0] OP_UNMASK    = 3'd4;
    localparam logic [2:0] OP_ARRIVAL   = 3'd5;
    localparam logic [2:0] OP_SET_DEST  = 3'd6;
    localparam logic [2:0] OP_QUERY     = 3'd7;

    localparam logic [1:0] HW_NONE  = 2'd0;
    localparam logic [1:0] HW_LOW   = 2'd1;
    localparam logic [1:0] HW_HIGH  = 2'd2;
    localparam logic [1:0] HW_WHOLE = 2'd3;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_RANGE     = 2'd1;
    localparam logic [1:0] ERR_NO_VECTOR = 2'd2;

    localparam logic [1:0] REG_LINE_COUNT  = 2'd0;
    localparam logic [1:0] REG_VECTOR_BASE = 2'd1;
    localparam logic [1:0] REG_VECTOR_LIM  = 2'd2;
    localparam logic [1:0] REG_SPURIOUS    = 2'd3;

    localparam logic [LINE_W-1:0] LINE_NINE = 6'd9;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [LINE_W-1:0] line;
        logic              level_mode;
        logic              active_low;
        logic [DEST_W-1:0] dest_id;
    } t_in_item;

    typedef struct packed {
        logic              deliver;
        logic              keep_masked;
        logic [1:0]        hw_update;
        logic [VEC_W-1:0]  line_vector;
        logic              line_masked;
        logic              line_level;
        logic              line_active_low;
        logic [DEST_W-1:0] line_dest;
        logic              pending_flag;
        logic              available;
        logic [1:0]        error;
    } t_out_item;

    typedef struct packed {
        logic [COUNT_W-1:0] line_count;
        logic [VEC_W-1:0]   vector_base;
        logic [LIMIT_W-1:0] vector_limit;
        logic [VEC_W-1:0]   spurious_vector;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic              level;
        logic              active_low;
        logic              mask;
        logic              pending;
        logic              assigned;
        logic [VEC_W-1:0]  vector;
        logic [DEST_W-1:0] dest;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{
        valid:      1'b0,
        level:      1'b0,
        active_low: 1'b0,
        mask:       1'b1,
        pending:    1'b0,
        assigned:   1'b0,
        vector:     '0,
        dest:       '0
    };

endpackage

@@ rtl/irqlm_regs.sv @@
module irqlm_regs
    import irqlm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_count      <= '0;
            r_cfg.vector_base     <= 8'd32;
            r_cfg.vector_limit    <= 9'd240;
            r_cfg.spurious_vector <= 8'd255;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_LINE_COUNT:  r_cfg.line_count      <= pwdata[COUNT_W-1:0];
                REG_VECTOR_BASE: r_cfg.vector_base     <= pwdata[VEC_W-1:0];
                REG_VECTOR_LIM:  r_cfg.vector_limit    <= pwdata[LIMIT_W-1:0];
                REG_SPURIOUS:    r_cfg.spurious_vector <= pwdata[VEC_W-1:0];
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_LINE_COUNT:  prdata = {{(PDATA_W-COUNT_W){1'b0}}, r_cfg.line_count};
            REG_VECTOR_BASE: prdata = {{(PDATA_W-VEC_W){1'b0}}, r_cfg.vector_base};
            REG_VECTOR_LIM:  prdata = {{(PDATA_W-LIMIT_W){1'b0}}, r_cfg.vector_limit};
            REG_SPURIOUS:    prdata = {{(PDATA_W-VEC_W){1'b0}}, r_cfg.spurious_vector};
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/irq_redirection_lazy_mask.sv @@
// Interrupt-line redirection table with lazy masking of edge lines. Each item applies one
// opcode to one line and yields exactly one result item: the line's state after the step,
// the hardware entry write it causes and an error code. The block accepts one item per clock
// cycle unless the output stalls; the table is read at the accepting edge, and the update,
// table write and result register load happen at the edge on which the item advances. The
// line table lives in a memory with one read and one write port and a per-line written bit
// that reset clears, so the table reads as reset right after reset without any clearing pass;
// a write from the preceding item is forwarded to the next. Configuration registers sit on the
// APB port; the user must write them only while the block is idle; the block does not check.
module irq_redirection_lazy_mask
    import irqlm_pkg::*;
#(
    parameter int NUM_LINES = 64
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int          AW      = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam logic [8:0]  NLINES9 = 9'(NUM_LINES);

    t_cfg cfg;

    irqlm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    t_entry                r_mem [NUM_LINES];
    logic [NUM_LINES-1:0]  r_written;
    t_entry                r_rd;

    t_in_item              r_in;
    logic                  r_s1_valid;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic                  r_fwd_valid;
    logic [AW-1:0]         r_fwd_addr;
    t_entry                r_fwd_entry;

    logic                  advance;
    logic                  accept;
    logic [AW+LINE_W-1:0]  in_addr_ext;
    logic [AW+LINE_W-1:0]  s1_addr_ext;
    logic [AW-1:0]         in_addr;
    logic [AW-1:0]         s1_addr;
    logic [8:0]            eff_count;
    logic                  out_of_range;
    logic [8:0]            vec_sum;
    t_entry                cur;
    t_entry                n_entry;
    t_out_item             n_out;
    logic                  wr_en;

    assign advance    = r_s1_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_s1_valid & ~advance;
    assign accept     = i_in_valid & ~o_in_stall;

    assign in_addr_ext = {{AW{1'b0}}, i_in_item.line};
    assign s1_addr_ext = {{AW{1'b0}}, r_in.line};
    assign in_addr     = in_addr_ext[AW-1:0];
    assign s1_addr     = s1_addr_ext[AW-1:0];

    assign eff_count    = ({2'b00, cfg.line_count} > NLINES9) ? NLINES9
                                                              : {2'b00, cfg.line_count};
    assign out_of_range = ({3'b000, r_in.line} >= eff_count);
    assign vec_sum      = {1'b0, cfg.vector_base} + {3'b000, r_in.line};

    // take the last write when it hit this line, else the table or its reset value
    always_comb begin
        if (r_fwd_valid && r_fwd_addr == s1_addr) begin
            cur = r_fwd_entry;
        end else if (r_written[s1_addr]) begin
            cur = r_rd;
        end else begin
            cur = ENTRY_RESET;
        end
    end

    always_comb begin
        n_entry = cur;
        n_out   = '0;
        n_out.error = ERR_OK;
        n_out.hw_update = HW_NONE;
        unique case (r_in.opcode)
            OP_CONFIGURE: begin
                n_entry.valid      = 1'b1;
                n_entry.level      = r_in.level_mode;
                n_entry.active_low = r_in.active_low;
                n_entry.mask       = 1'b1;
                n_entry.pending    = 1'b0;
                n_entry.assigned   = 1'b0;
                n_out.hw_update    = HW_WHOLE;
            end
            OP_ENABLE: begin
                if (!cur.assigned) begin
                    if (vec_sum >= cfg.vector_limit) begin
                        n_out.error = ERR_NO_VECTOR;
                    end else begin
                        n_entry.vector   = vec_sum[VEC_W-1:0];
                        n_entry.assigned = 1'b1;
                    end
                end
                if (n_out.error == ERR_OK) begin
                    n_entry.pending = 1'b0;
                    n_entry.mask    = 1'b0;
                    n_out.hw_update = HW_LOW;
                end
            end
            OP_DISABLE: begin
                n_entry.assigned = 1'b0;
                n_entry.pending  = 1'b0;
                n_entry.mask     = 1'b1;
                n_out.hw_update  = HW_LOW;
            end
            OP_MASK: begin
                n_entry.mask    = 1'b1;
                n_out.hw_update = cur.level ? HW_LOW : HW_NONE;
            end
            OP_UNMASK: begin
                if (!cur.level) begin
                    // pending edge: drop it and leave the line masked
                    if (cur.pending) begin
                        n_entry.pending   = 1'b0;
                        n_out.keep_masked = 1'b1;
                    end else begin
                        n_entry.mask = 1'b0;
                    end
                end else begin
                    n_entry.mask    = 1'b0;
                    n_out.hw_update = HW_LOW;
                end
            end
            OP_ARRIVAL: begin
                n_out.deliver = 1'b1;
                if (!cur.level && cur.mask) begin
                    n_entry.pending = 1'b1;
                    n_out.deliver   = 1'b0;
                end
                n_entry.mask    = 1'b1;
                n_out.hw_update = cur.level ? HW_LOW : HW_NONE;
            end
            OP_SET_DEST: begin
                if (cur.dest != r_in.dest_id) begin
                    n_entry.dest    = r_in.dest_id;
                    n_out.hw_update = HW_HIGH;
                end
            end
            OP_QUERY: begin
            end
        endcase

        n_out.line_vector     = n_entry.assigned ? n_entry.vector : cfg.spurious_vector;
        n_out.line_masked     = n_entry.mask;
        n_out.line_level      = n_entry.level;
        n_out.line_active_low = n_entry.active_low;
        n_out.line_dest       = n_entry.dest;
        n_out.pending_flag    = n_entry.pending;
        n_out.available       = n_entry.valid & (r_in.line != LINE_NINE);

        if (out_of_range) begin
            n_out             = '0;
            n_out.line_vector = cfg.spurious_vector;
            n_out.error       = ERR_RANGE;
        end
    end

    assign wr_en = advance & ~out_of_range;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[s1_addr] <= n_entry;
        end
        if (accept) begin
            r_rd <= r_mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written   <= '0;
            r_fwd_valid <= 1'b0;
        end else if (wr_en) begin
            r_written[s1_addr] <= 1'b1;
            r_fwd_valid        <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_fwd_addr  <= s1_addr;
            r_fwd_entry <= n_entry;
        end
        if (accept) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out_item <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
